[hw/rtl/esp_pkg.sv]
// Shared widths, constants and types for the encoder speed estimator.
package esp_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int DT_W    = 20;
    localparam int SPD_W   = 25;
    // Magnitude of an unwrapped difference scaled by 256
    localparam int PROD_W  = 24;

    // Unwrap threshold: 0.7 turn in 1/65536-turn units
    localparam logic signed [ANGLE_W:0] WRAP_LIMIT = 17'sd45875;
    // One full turn, modulo the 17-bit difference width
    localparam logic signed [ANGLE_W:0] TURN = 17'sh10000;

    localparam int DEF_AVG_DEPTH = 8;

    // Ring control issued by the sequencer
    typedef struct packed {
        logic rd;   // fetch the slot that the next update overwrites
        logic upd;  // overwrite the slot, adjust the sum, advance the position
    } t_ring_ctl;

endpackage

[hw/rtl/esp_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module esp_serial_div
    import esp_pkg::*;
#(
    parameter int DVD_W = 28,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,  // left aligned, i_nbits significant bits
    input  logic [DT_W-1:0]  i_divisor,   // nonzero
    input  logic [CNT_W-1:0] i_nbits,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  r_d;

    logic [DT_W:0]    w_trial;
    logic [DT_W:0]    w_diff;
    logic             w_ge;

    // Shift the next dividend bit into the partial remainder and try a subtract
    always_comb begin
        w_trial = {r_rem, r_q[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        w_ge    = (w_trial >= {1'b0, r_d});
    end

    // Control: count iterations, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top as quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DT_W-1:0] : w_trial[DT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_d))
        else $error("partial remainder not below divisor");

endmodule

[hw/rtl/esp_ring.sv]
// Ring of recent speeds with a running sum.
module esp_ring
    import esp_pkg::*;
#(
    parameter int DEPTH = DEF_AVG_DEPTH,
    parameter int SUM_W = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ring_ctl               i_ctl,
    input  logic signed [SPD_W-1:0] i_data,
    output logic signed [SUM_W-1:0] o_sum
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [SPD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_vld;
    logic [PTR_W-1:0]        r_pos;
    logic signed [SPD_W-1:0] r_rd;
    logic                    r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SPD_W-1:0] w_old;

    // Read the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd     <= r_mem[r_pos];
            r_rd_vld <= r_vld[r_pos];
        end
    end

    // Write the new speed into the slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_mem[r_pos] <= i_data;
        end
    end

    // A slot never written counts as a zero speed
    assign w_old = r_rd_vld ? r_rd : '0;

    // Update valid bits, sum and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_ctl.upd) begin
            r_vld[r_pos] <= 1'b1;
            r_sum        <= r_sum - SUM_W'(w_old) + SUM_W'(i_data);
            r_pos        <= (r_pos == PTR_W'(DEPTH - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    assign o_sum = r_sum;

endmodule

[hw/rtl/encoder_speed_estimator.sv]
// Encoder speed estimator top level: unwrap, serial divide, moving average.
//
// Input channel (i_valid / o_ready) carries an angle, an elapsed time and a
// prime flag. A primed transfer only latches the angle as the reference and
// produces nothing; the block is ready again in the next cycle. A normal
// transfer produces one result on the output channel (o_valid / i_ready):
// the instantaneous speed, angle difference * 256 / dt, and the mean of the
// last AVG_DEPTH speeds, both truncated toward zero. A zero dt counts as one.
// SUM_W = 25 + clog2(AVG_DEPTH), with AVG_DEPTH 8 by default.
// One shared bit-serial divider does both divisions: a 24-bit quotient
// for the speed, then a SUM_W-bit quotient for the mean. The block takes
// no new item until the previous one has passed both divisions and
// reached the output stage.
// The result sits in an output register; a new item is accepted while it
// waits, but its result is held back until the receiver takes the old one.
// Reset clears the reference angle, the ring (all speeds zero), the sum and
// the output valid.
module encoder_speed_estimator
    import esp_pkg::*;
#(
    parameter int AVG_DEPTH = DEF_AVG_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ANGLE_W-1:0]      i_angle,
    input  logic [DT_W-1:0]         i_dt,
    input  logic                    i_prime,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SPD_W-1:0] o_inst_speed,
    output logic signed [SPD_W-1:0] o_avg_speed
);

    localparam int SUM_W = SPD_W + $clog2(AVG_DEPTH);
    localparam int CNT_W = $clog2(SUM_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_AVG  = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]              r_state;
    logic [ANGLE_W-1:0]      r_prev;
    logic                    r_neg;
    logic [ANGLE_W-1:0]      r_mag;
    logic [DT_W-1:0]         r_dt;
    logic signed [SPD_W-1:0] r_inst;
    logic                    r_sneg;
    logic signed [SPD_W-1:0] r_avg;
    logic                    r_o_valid;
    logic signed [SPD_W-1:0] r_o_inst;
    logic signed [SPD_W-1:0] r_o_avg;

    logic                    w_accept;
    logic signed [ANGLE_W:0] w_raw;
    logic signed [ANGLE_W:0] w_diff;
    logic signed [ANGLE_W:0] w_abs;
    logic                    w_div_start;
    logic [SUM_W-1:0]        w_dividend;
    logic [DT_W-1:0]         w_divisor;
    logic [CNT_W-1:0]        w_nbits;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quot;
    logic signed [SPD_W-1:0] w_qmag;
    t_ring_ctl               w_ring_ctl;
    logic signed [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0]        w_sum_abs;
    logic                    w_out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Difference from the reference angle, unwrapped into +-0.7 turn
    always_comb begin
        w_raw = $signed({1'b0, i_angle}) - $signed({1'b0, r_prev});
        if (w_raw > WRAP_LIMIT) begin
            w_diff = w_raw - TURN;
        end else if (w_raw < -WRAP_LIMIT) begin
            w_diff = w_raw + TURN;
        end else begin
            w_diff = w_raw;
        end
        w_abs = w_diff[ANGLE_W] ? -w_diff : w_diff;
    end

    // Divider operands: speed first, then the ring mean
    assign w_sum_abs = w_sum[SUM_W-1] ? SUM_W'(-w_sum) : SUM_W'(w_sum);
    always_comb begin
        if (r_state == S_AVG) begin
            w_dividend = w_sum_abs;
            w_divisor  = DT_W'(AVG_DEPTH);
            w_nbits    = CNT_W'(SUM_W);
        end else begin
            w_dividend = {r_mag, {(SUM_W - ANGLE_W){1'b0}}};
            w_divisor  = r_dt;
            w_nbits    = CNT_W'(PROD_W);
        end
    end
    assign w_div_start = (r_state == S_PREP) || (r_state == S_AVG);

    assign w_ring_ctl.rd  = (r_state == S_PREP);
    assign w_ring_ctl.upd = (r_state == S_SUM);

    assign w_qmag     = $signed({1'b0, w_quot[PROD_W-1:0]});
    assign w_out_free = !r_o_valid || i_ready;

    esp_serial_div #(
        .DVD_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_nbits    (w_nbits),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    esp_ring #(
        .DEPTH (AVG_DEPTH),
        .SUM_W (SUM_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .i_data  (r_inst),
        .o_sum   (w_sum)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_prev <= i_angle;
                        if (!i_prime) begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: r_state <= S_DIV1;
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM:  r_state <= S_AVG;
                S_AVG:  r_state <= S_DIV2;
                S_DIV2: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture operands and quotients
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_prime) begin
            r_neg <= w_diff[ANGLE_W];
            r_mag <= w_abs[ANGLE_W-1:0];
            r_dt  <= (i_dt == '0) ? DT_W'(1) : i_dt;
        end
        if (r_state == S_DIV1 && w_div_done) begin
            r_inst <= r_neg ? -w_qmag : w_qmag;
        end
        if (r_state == S_AVG) begin
            r_sneg <= w_sum[SUM_W-1];
        end
        if (r_state == S_DIV2 && w_div_done) begin
            r_avg <= r_sneg ? -w_qmag : w_qmag;
        end
    end

    // Output register: load when free, drop valid on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_inst <= r_inst;
            r_o_avg  <= r_avg;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_inst_speed = r_o_inst;
    assign o_avg_speed  = r_o_avg;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside a divide state");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the encoder speed estimator: unwrap, divide, moving average.
module tb_top;
    import esp_pkg::*;

    localparam int     RING_DEPTH  = DEF_AVG_DEPTH;
    localparam longint WRAP_UNITS  = 45875;
    localparam longint TURN_UNITS  = 65536;
    localparam longint SPEED_SCALE = 256;
    localparam int     RANDOM_ITEMS = 530;
    localparam int     DRAIN_AT     = 300;
    localparam int     LONG_HOLD_AT = 60;
    localparam int     LONG_HOLD    = 500;
    localparam int     STUCK_LIMIT  = 3000;
    localparam int     REPORT_MAX   = 10;

    typedef struct {
        logic signed [SPD_W-1:0] inst;
        logic signed [SPD_W-1:0] avg;
    } t_speed_pair;

    // Predicts speed pairs from accepted samples and checks the block's output
    class t_speed_scoreboard;
        logic [ANGLE_W-1:0]      ref_angle;
        logic signed [SPD_W-1:0] ring [RING_DEPTH];
        int                      ring_slot;
        longint                  ring_total;
        t_speed_pair             expected_q[$];
        int                      mismatches;
        int                      results_checked;

        function new();
            ref_angle = '0;
            foreach (ring[i]) ring[i] = '0;
            ring_slot = 0;
            ring_total = 0;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Latch the reference on a priming sample; otherwise predict one result
        function void note_input(logic [ANGLE_W-1:0] angle, logic [DT_W-1:0] dt,
                                 logic prime);
            longint      cur_angle, last_angle, diff, divisor, speed;
            t_speed_pair pair;
            cur_angle  = longint'(angle);
            last_angle = longint'(ref_angle);
            ref_angle  = angle;
            if (prime) return;
            divisor = (dt == '0) ? longint'(1) : longint'(dt);
            diff = cur_angle - last_angle;
            if (diff > WRAP_UNITS) diff -= TURN_UNITS;
            else if (diff < -WRAP_UNITS) diff += TURN_UNITS;
            speed = (diff * SPEED_SCALE) / divisor;
            // Replace the oldest ring entry and keep the running total
            ring_total -= ring[ring_slot];
            ring[ring_slot] = SPD_W'(speed);
            ring_total += speed;
            ring_slot = (ring_slot + 1) % RING_DEPTH;
            pair.inst = SPD_W'(speed);
            pair.avg  = SPD_W'(ring_total / RING_DEPTH);
            expected_q.push_back(pair);
        endfunction

        function void check_result(logic signed [SPD_W-1:0] inst,
                                   logic signed [SPD_W-1:0] avg);
            t_speed_pair pair;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result inst=%0d avg=%0d", inst, avg);
                return;
            end
            pair = expected_q.pop_front();
            if (pair.inst !== inst || pair.avg !== avg) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result %0d: inst exp %0d got %0d, avg exp %0d got %0d",
                             results_checked, pair.inst, inst, pair.avg, avg);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ANGLE_W-1:0]      in_angle = '0;
    logic [DT_W-1:0]         in_dt = '0;
    logic                    in_prime = 1'b0;
    logic                    o_valid;
    logic                    out_ready = 1'b0;
    logic signed [SPD_W-1:0] o_inst_speed;
    logic signed [SPD_W-1:0] o_avg_speed;

    t_speed_scoreboard sb = new();

    logic [ANGLE_W-1:0] sent_angle = '0;
    int items_sent = 0;
    int primes_sent = 0;
    int results_seen = 0;
    int stuck_cycles = 0;

    encoder_speed_estimator #(.AVG_DEPTH(RING_DEPTH)) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_angle      (in_angle),
        .i_dt         (in_dt),
        .i_prime      (in_prime),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_inst_speed (o_inst_speed),
        .o_avg_speed  (o_avg_speed)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one sample after an optional gap and hold it until the transfer
    task automatic send_sample(input logic [ANGLE_W-1:0] angle, input logic [DT_W-1:0] dt,
                               input logic prime, input bit allow_gaps);
        int gap;
        gap = allow_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_angle <= angle;
        in_dt    <= dt;
        in_prime <= prime;
        do @(posedge clk); while (!in_ready);
        sent_angle = angle;
        items_sent++;
        if (prime) primes_sent++;
    endtask

    // Stop offering and wait for every predicted result to arrive
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Pick the next angle: mostly near the last one, often at the unwrap edges
    function automatic logic [ANGLE_W-1:0] pick_angle(logic [ANGLE_W-1:0] last);
        int step;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: step = $urandom_range(0, 4000) - 2000;
            4, 5:       step = $urandom_range(45870, 45881);
            6:          step = $urandom_range(65520, 65535);
            7, 8:       step = $urandom_range(0, 65535);
            default:    step = 0;
        endcase
        if ($urandom_range(0, 1)) step = -step;
        return ANGLE_W'(int'(last) + step);
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DT_W'($urandom_range(1, 64));
            5, 6:          return DT_W'($urandom_range(1, 1048575));
            7:             return DT_W'($urandom_range(1, 4095));
            8: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return 20'd1;
                    default: return '1;
                endcase
            end
            default:       return DT_W'($urandom);
        endcase
    endfunction

    // Count transfers, feed the scoreboard, and watch for a stuck block
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_input(in_angle, in_dt, in_prime);
            if (o_valid && out_ready) sb.check_result(o_inst_speed, o_avg_speed);
            if ((in_valid && in_ready) || (o_valid && out_ready)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stalls, calm stretches, and one long hold-off
    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD;
            else if ((results_seen / 30) % 3 == 1) stall = 0;
            else stall = $urandom_range(0, 15);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_valid);
            results_seen++;
        end
    end

    // Sample side: directed corners, then random samples, then wrap up
    initial begin
        logic [ANGLE_W-1:0] angle;
        bit                 gaps_on;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Zero motion, largest forward and backward steps without unwrap
        send_sample(16'd0, 20'd1, 1'b0, 1'b0);
        send_sample(16'd45875, 20'd1, 1'b0, 1'b0);
        send_sample(16'd0, 20'd1, 1'b0, 1'b1);
        // Just past the limit in each direction; zero dt counts as one
        send_sample(16'd45876, 20'd0, 1'b0, 1'b1);
        send_sample(16'd0, 20'hFFFFF, 1'b0, 1'b0);
        // Wrap across the turn boundary both ways after priming
        send_sample(16'hFFFF, 20'd3, 1'b1, 1'b1);
        send_sample(16'd0, 20'd3, 1'b0, 1'b0);
        send_sample(16'd0, 20'd7, 1'b1, 1'b1);
        send_sample(16'hFFFF, 20'd7, 1'b0, 1'b1);
        send_sample(16'hFFFF, 20'd5, 1'b0, 1'b0);
        // Alternating bit patterns on angle and dt
        send_sample(16'hAAAA, 20'h55555, 1'b0, 1'b1);
        send_sample(16'h5555, 20'hAAAAA, 1'b0, 1'b0);
        send_sample(16'h8000, 20'd2, 1'b0, 1'b1);
        send_sample(16'h8000, 20'd2, 1'b1, 1'b1);
        // Enough further samples to wrap the ring
        repeat (8) send_sample(pick_angle(sent_angle), pick_dt(), 1'b0, 1'b1);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT) drain_results();
            gaps_on = ((n / 40) % 3) != 2;
            angle = pick_angle(sent_angle);
            send_sample(angle, pick_dt(), ($urandom_range(0, 7) == 0), gaps_on);
        end

        drain_results();
        repeat (100) @(posedge clk);
        $display("Covered %0d samples (%0d priming) and checked %0d speed results,",
                 items_sent, primes_sent, sb.results_checked);
        $display("including unwrap limits, zero dt, full-scale dt and a long output stall.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("mismatches: %0d, results missing: %0d", sb.mismatches, sb.pending());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
